// ----- src/atrp_pkg.sv -----
package atrp_pkg;

   localparam int TABLE_LEN = 24;
   localparam int GUARD_BITS = 16;
   localparam longint GAIN_Q30 = 64'sd1768195363;
   localparam longint DEG180 = 64'sd11796480;
   localparam int ROLL_MAX = 23040;
   localparam int PITCH_MAX = 11520;
   localparam int ACC_BITS = 26;

   typedef logic signed [ACC_BITS-1:0] angle_type;

   function automatic angle_type atan_deg(input int idx);
      angle_type r;
      unique case (idx)
         0: r = 26'sd2949120;
         1: r = 26'sd1740967;
         2: r = 26'sd919879;
         3: r = 26'sd466945;
         4: r = 26'sd234379;
         5: r = 26'sd117304;
         6: r = 26'sd58666;
         7: r = 26'sd29335;
         8: r = 26'sd14668;
         9: r = 26'sd7334;
         10: r = 26'sd3667;
         11: r = 26'sd1833;
         12: r = 26'sd917;
         13: r = 26'sd458;
         14: r = 26'sd229;
         15: r = 26'sd115;
         16: r = 26'sd57;
         17: r = 26'sd29;
         18: r = 26'sd14;
         19: r = 26'sd7;
         20: r = 26'sd4;
         21: r = 26'sd2;
         22: r = 26'sd1;
         default: r = '0;
      endcase
      return r;
   endfunction

endpackage

// ----- src/atrp_if.sv -----
interface atrp_if #(
   parameter int PAYLOAD_BITS = 48
) (
   input logic clock
);
   logic valid;
   logic ready;
   logic [PAYLOAD_BITS-1:0] payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

// ----- src/atrp_cell.sv -----
module atrp_cell #(
   parameter int STEP = 0,
   parameter bit ROT_ON = 1'b1,
   parameter int VW = 40,
   parameter int SW = 16,
   parameter int MW = 34,
   parameter int RW = 17
) (
   input  logic clock,
   input  logic enable,
   input  logic signed [VW-1:0] x1_in_d,
   input  logic signed [VW-1:0] y1_in_d,
   input  atrp_pkg::angle_type a1_in_d,
   input  logic signed [SW-1:0] ax_in_d,
   input  logic [MW-1:0] rem_in_d,
   input  logic [RW-1:0] root_in_d,
   output logic signed [VW-1:0] x1_out,
   output logic signed [VW-1:0] y1_out,
   output atrp_pkg::angle_type a1_out,
   output logic signed [SW-1:0] ax_out,
   output logic [MW-1:0] rem_out,
   output logic [RW-1:0] root_out
);
   localparam int SH = (STEP < atrp_pkg::TABLE_LEN) ? STEP : 0;
   localparam bit ACTIVE = ROT_ON && (STEP < atrp_pkg::TABLE_LEN);
   localparam int BITPOS = 2 * (RW - 1 - STEP);

   logic signed [VW-1:0] x1_ff, y1_ff, x1_in, y1_in;
   atrp_pkg::angle_type a1_ff, a1_in;
   logic signed [SW-1:0] ax_ff;
   logic [MW-1:0] rem_ff, rem_in;
   logic [RW-1:0] root_ff, root_in;
   logic [MW+1:0] trial;

   always_comb begin
      x1_in = x1_in_d;
      y1_in = y1_in_d;
      a1_in = a1_in_d;
      if (ACTIVE) begin
         if (y1_in_d < 0) begin
            x1_in = x1_in_d - (y1_in_d >>> SH);
            y1_in = y1_in_d + (x1_in_d >>> SH);
            a1_in = a1_in_d - atrp_pkg::atan_deg(SH);
         end else begin
            x1_in = x1_in_d + (y1_in_d >>> SH);
            y1_in = y1_in_d - (x1_in_d >>> SH);
            a1_in = a1_in_d + atrp_pkg::atan_deg(SH);
         end
      end
      rem_in = rem_in_d;
      root_in = root_in_d;
      trial = '0;
      if (STEP < RW && BITPOS >= 0) begin
         trial = ({2'b00, {(MW - RW){1'b0}}, root_in_d} << (RW - STEP))
               | ((MW + 2)'(1) << BITPOS);
         if ({2'b00, rem_in_d} >= trial) begin
            rem_in = rem_in_d - trial[MW-1:0];
            root_in = root_in_d | (RW'(1) << (RW - 1 - STEP));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         x1_ff <= x1_in;
         y1_ff <= y1_in;
         a1_ff <= a1_in;
         ax_ff <= ax_in_d;
         rem_ff <= rem_in;
         root_ff <= root_in;
      end
   end

   assign x1_out = x1_ff;
   assign y1_out = y1_ff;
   assign a1_out = a1_ff;
   assign ax_out = ax_ff;
   assign rem_out = rem_ff;
   assign root_out = root_ff;
endmodule

// ----- src/atrp_pass2_cell.sv -----
module atrp_pass2_cell #(
   parameter int STEP = 0,
   parameter int VW = 40
) (
   input  logic clock,
   input  logic enable,
   input  logic signed [VW-1:0] x_in_d,
   input  logic signed [VW-1:0] y_in_d,
   input  atrp_pkg::angle_type a_in_d,
   output logic signed [VW-1:0] x_out,
   output logic signed [VW-1:0] y_out,
   output atrp_pkg::angle_type a_out
);
   localparam int SH = (STEP < atrp_pkg::TABLE_LEN) ? STEP : 0;
   localparam bit ACTIVE = STEP < atrp_pkg::TABLE_LEN;

   logic signed [VW-1:0] x_ff, y_ff, x_in, y_in;
   atrp_pkg::angle_type a_ff, a_in;

   always_comb begin
      x_in = x_in_d;
      y_in = y_in_d;
      a_in = a_in_d;
      if (ACTIVE) begin
         if (y_in_d < 0) begin
            x_in = x_in_d - (y_in_d >>> SH);
            y_in = y_in_d + (x_in_d >>> SH);
            a_in = a_in_d - atrp_pkg::atan_deg(SH);
         end else begin
            x_in = x_in_d + (y_in_d >>> SH);
            y_in = y_in_d - (x_in_d >>> SH);
            a_in = a_in_d + atrp_pkg::atan_deg(SH);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         x_ff <= x_in;
         y_ff <= y_in;
         a_ff <= a_in;
      end
   end

   assign x_out = x_ff;
   assign y_out = y_ff;
   assign a_out = a_ff;
endmodule

// ----- src/accel_tilt_roll_pitch_unit.sv -----
// Tilt unit: for each accelerometer item (x, y, z) gives roll = atan2(y, z),
// pitch = atan2(-x, sqrt(y^2+z^2)) in 1/128 degree, saturated to +-180 and
// +-90 degrees, and floor(sqrt(x^2+y^2+z^2)) saturated to 65535. A new item is
// taken every cycle unless a result is stalled; each item passes through an
// input register, two rows of CORDIC cells (roll pass with the square-root
// digits computed along it, then pitch pass fed by the roll pass magnitude),
// the gain multiply register and the output register. A stalled result stalls
// the whole row and holds off the input until it is taken.
module accel_tilt_roll_pitch_unit #(
   parameter int CORDIC_STEPS = 16,
   parameter int SAMPLE_BITS = 16
) (
   input logic clock,
   input logic reset,
   atrp_if.sink req,
   atrp_if.source rsp
);
   localparam int SW = SAMPLE_BITS;
   localparam int VW = SW + 24;
   localparam int MW = 2 * SW + 2;
   localparam int RW = SW + 1;
   localparam int N1 = (CORDIC_STEPS > RW) ? CORDIC_STEPS : RW;
   localparam int N2 = CORDIC_STEPS;
   localparam int DEPTH = N1 + N2 + 3;
   localparam int PW = SW + 33;

   logic [DEPTH-1:0] vld_ff, vld_in;
   logic advance;

   // input stage
   logic signed [SW-1:0] ax0_ff, ay0_ff, az0_ff;
   logic signed [VW-1:0] x1s, y1s;
   atrp_pkg::angle_type a1s;
   logic [MW-1:0] sq0;
   logic [2*SW-1:0] sqx, sqy, sqz;
   logic signed [2*SW-1:0] ex, ey, ez;

   assign advance = !rsp.valid || rsp.ready;
   assign req.ready = advance;

   always_ff @(posedge clock) begin
      if (advance) begin
         ax0_ff <= req.payload[SW-1:0];
         ay0_ff <= req.payload[2*SW-1:SW];
         az0_ff <= req.payload[3*SW-1:2*SW];
      end
   end

   always_comb begin
      logic signed [VW-1:0] zv, yv;
      zv = VW'(az0_ff) <<< atrp_pkg::GUARD_BITS;
      yv = VW'(ay0_ff) <<< atrp_pkg::GUARD_BITS;
      x1s = zv;
      y1s = yv;
      a1s = '0;
      if (zv < 0) begin
         x1s = -zv;
         y1s = -yv;
         a1s = (yv < 0) ? -atrp_pkg::angle_type'(atrp_pkg::DEG180)
                        : atrp_pkg::angle_type'(atrp_pkg::DEG180);
      end
      ex = (2 * SW)'(ax0_ff);
      ey = (2 * SW)'(ay0_ff);
      ez = (2 * SW)'(az0_ff);
      sqx = $unsigned(ex * ex);
      sqy = $unsigned(ey * ey);
      sqz = $unsigned(ez * ez);
      sq0 = MW'(sqx) + MW'(sqy) + MW'(sqz);
   end

   logic signed [VW-1:0] cx [N1+1];
   logic signed [VW-1:0] cy [N1+1];
   atrp_pkg::angle_type ca [N1+1];
   logic signed [SW-1:0] cax [N1+1];
   logic [MW-1:0] crem [N1+1];
   logic [RW-1:0] croot [N1+1];

   assign cx[0] = x1s;
   assign cy[0] = y1s;
   assign ca[0] = a1s;
   assign cax[0] = ax0_ff;
   assign crem[0] = sq0;
   assign croot[0] = '0;

   for (genvar g = 0; g < N1; g++) begin : g_row1
      atrp_cell #(
         .STEP(g), .ROT_ON(g < CORDIC_STEPS),
         .VW(VW), .SW(SW), .MW(MW), .RW(RW)
      ) u_cell (
         .clock(clock), .enable(advance),
         .x1_in_d(cx[g]), .y1_in_d(cy[g]), .a1_in_d(ca[g]), .ax_in_d(cax[g]),
         .rem_in_d(crem[g]), .root_in_d(croot[g]),
         .x1_out(cx[g+1]), .y1_out(cy[g+1]), .a1_out(ca[g+1]), .ax_out(cax[g+1]),
         .rem_out(crem[g+1]), .root_out(croot[g+1])
      );
   end

   // gain multiply of -x, hold roll and magnitude
   logic signed [VW-1:0] mx_ff, my_ff;
   atrp_pkg::angle_type roll_acc_ff, roll_acc2 [N2+1];
   logic [RW-1:0] mag_ff, mag2 [N2+1];
   logic signed [PW-1:0] prod;

   always_comb begin
      prod = (-PW'(cax[N1])) * PW'(atrp_pkg::GAIN_Q30);
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         mx_ff <= cx[N1];
         my_ff <= VW'(prod >>> (30 - atrp_pkg::GUARD_BITS));
         roll_acc_ff <= ca[N1];
         mag_ff <= croot[N1];
      end
   end

   logic signed [VW-1:0] px [N2+1];
   logic signed [VW-1:0] py [N2+1];
   atrp_pkg::angle_type pa [N2+1];

   assign px[0] = mx_ff;
   assign py[0] = my_ff;
   assign pa[0] = '0;
   assign roll_acc2[0] = roll_acc_ff;
   assign mag2[0] = mag_ff;

   for (genvar g = 0; g < N2; g++) begin : g_row2
      atrp_pass2_cell #(.STEP(g), .VW(VW)) u_cell (
         .clock(clock), .enable(advance),
         .x_in_d(px[g]), .y_in_d(py[g]), .a_in_d(pa[g]),
         .x_out(px[g+1]), .y_out(py[g+1]), .a_out(pa[g+1])
      );
      always_ff @(posedge clock) begin
         if (advance) begin
            roll_acc2[g+1] <= roll_acc2[g];
            mag2[g+1] <= mag2[g];
         end
      end
   end

   // output register
   logic signed [15:0] roll_ff;
   logic signed [14:0] pitch_ff;
   logic [15:0] mag_out_ff;
   atrp_pkg::angle_type rr, pr;

   always_comb begin
      rr = (roll_acc2[N2] + atrp_pkg::angle_type'(256)) >>> 9;
      pr = (pa[N2] + atrp_pkg::angle_type'(256)) >>> 9;
      if (rr > atrp_pkg::angle_type'(atrp_pkg::ROLL_MAX))
         rr = atrp_pkg::angle_type'(atrp_pkg::ROLL_MAX);
      if (rr < -atrp_pkg::angle_type'(atrp_pkg::ROLL_MAX))
         rr = -atrp_pkg::angle_type'(atrp_pkg::ROLL_MAX);
      if (pr > atrp_pkg::angle_type'(atrp_pkg::PITCH_MAX))
         pr = atrp_pkg::angle_type'(atrp_pkg::PITCH_MAX);
      if (pr < -atrp_pkg::angle_type'(atrp_pkg::PITCH_MAX))
         pr = -atrp_pkg::angle_type'(atrp_pkg::PITCH_MAX);
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         roll_ff <= rr[15:0];
         pitch_ff <= pr[14:0];
         mag_out_ff <= (mag2[N2] > RW'(16'hFFFF)) ? 16'hFFFF : mag2[N2][15:0];
      end
   end

   always_comb begin
      vld_in = vld_ff;
      if (advance)
         vld_in = {vld_ff[DEPTH-2:0], req.valid};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   assign rsp.valid = vld_ff[DEPTH-1];
   assign rsp.payload = {mag_out_ff, 1'b0, pitch_ff, roll_ff};
endmodule
